// ===== src/pidaw_pkg.sv =====
package pidaw_pkg;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_DELTA,
        ST_ACC_ADD,
        ST_HI_MUL,
        ST_HI_DIV,
        ST_LO_MUL,
        ST_LO_DIV,
        ST_CLAMP,
        ST_I_MUL,
        ST_I_DIV,
        ST_D_MUL1,
        ST_D_MUL2,
        ST_D_DIV,
        ST_F_MUL,
        ST_FINISH,
        ST_EMIT
    } state_t;

    // serial unit operations
    typedef enum logic {
        OP_MUL,
        OP_DIV
    } alu_op_t;

    // request from sequencer to serial unit
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    // configuration register indexes
    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [2:0] REG_RAMP_GAIN     = 3'd3;
    localparam logic [2:0] REG_DRIVE_FLOOR   = 3'd4;
    localparam logic [2:0] REG_DRIVE_CEILING = 3'd5;

    // milliseconds per second
    localparam logic [15:0] MS_PER_S = 16'd1000;

    // fraction bits of the internal drive sum
    localparam int FRAC_BITS = 12;

endpackage

// ===== src/pid_antiwindup_feedforward.sv =====
// channel   | direction | contents
// s_axis    | in        | tdata: measured, target, ramp, step_ms; tuser: clear_state
// m_axis    | out       | tdata: drive
// cfg       | in        | register index and 16-bit write data
//
// a compute step runs its multiply and divide states in turn on one shared bit-serial
// multiply/divide unit MW bits wide, MW = max(ACCUM_BITS+16, 44); clear and zero-step
// items go straight from idle to the output stage.
// reset is synchronous, active low, and clears gains, state and the output stage.
// a stalled result sits in the output register; the next item is taken once
// the sequencer is back in idle.
module pid_antiwindup_feedforward
    import pidaw_pkg::*;
#(
    parameter int ACCUM_BITS = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // measured_temp, target_temp, ramp_rate, step_ms
    input  logic        s_tuser,   // clear_state
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // drive
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int A  = ACCUM_BITS;
    localparam int MW = (A + 16 > 44) ? A + 16 : 44;
    localparam int SW = MW + 3;
    localparam logic signed [SW-1:0] ACC_MAX_S =
        signed'({{(SW-A+1){1'b0}}, {(A-1){1'b1}}});
    localparam logic signed [SW-1:0] ACC_MIN_S =
        signed'({{(SW-A+1){1'b1}}, {(A-1){1'b0}}});
    localparam logic signed [A-1:0] ACC_MAX = signed'({1'b0, {(A-1){1'b1}}});
    localparam logic signed [A-1:0] ACC_MIN = signed'({1'b1, {(A-1){1'b0}}});

    // configuration
    logic [15:0]        prop_gain_reg;
    logic [15:0]        integ_gain_reg;
    logic [15:0]        deriv_gain_reg;
    logic signed [15:0] ramp_gain_reg;
    logic signed [15:0] drive_floor_reg;
    logic signed [15:0] drive_ceiling_reg;

    // controller state
    logic signed [A-1:0] accum_reg;
    logic signed [15:0]  last_reg;
    logic signed [15:0]  held_reg;
    logic                first_reg;

    // per-item working registers
    state_t              state_reg, state_next;
    logic signed [16:0]  e_reg;
    logic signed [16:0]  dm_reg;
    logic signed [15:0]  meas_reg;
    logic signed [15:0]  ramp_reg;
    logic [15:0]         step_reg;
    logic signed [32:0]  p_reg;
    logic signed [32:0]  delta_reg;
    logic signed [A-1:0] hi_reg;
    logic signed [A-1:0] lo_reg;
    logic [MW-1:0]       t_reg;
    logic                tneg_reg;
    logic signed [SW-1:0] sum_reg;
    logic                launched_reg;
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;

    // serial unit hookup
    alu_req_t            alu_req;
    logic [MW-1:0]       alu_a;
    logic [15:0]         alu_b;
    logic                alu_done;
    logic [MW-1:0]       alu_res;
    logic                is_op;
    logic                res_neg;
    logic signed [SW-1:0] res_s;
    logic [A-1:0]        sat_res;

    // derived operands
    logic [16:0]         e_abs, dm_abs, ramp_abs;
    logic [15:0]         rg_abs;
    logic [A-1:0]        acc_abs;
    logic signed [34:0]  x_hi, x_lo;
    logic [34:0]         x_hi_abs, x_lo_abs;
    logic signed [SW-1:0] acc_sum;
    logic signed [SW-1:0] rnd_sum, rnd_v;
    logic signed [SW-1:0] floor_s, ceil_s;
    logic signed [15:0]  drive_val;
    logic                s_fire;
    logic                out_free;

    pidaw_alu #(.MW(MW)) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a_in    (alu_a),
        .b_in    (alu_b),
        .done    (alu_done),
        .result  (alu_res)
    );

    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // magnitudes for the unsigned serial unit
    assign e_abs    = e_reg[16] ? 17'(-e_reg) : 17'(e_reg);
    assign dm_abs   = dm_reg[16] ? 17'(-dm_reg) : 17'(dm_reg);
    assign ramp_abs = ramp_reg[15] ? 17'(-17'(ramp_reg)) : 17'(ramp_reg);
    assign rg_abs   = ramp_gain_reg[15] ? 16'(-ramp_gain_reg) : 16'(ramp_gain_reg);
    assign acc_abs  = accum_reg[A-1] ? A'(-accum_reg) : A'(accum_reg);

    // anti-windup numerators: limit*4096 - p
    assign x_hi = 35'(signed'({drive_ceiling_reg, 12'd0})) - 35'(p_reg);
    assign x_lo = 35'(signed'({drive_floor_reg, 12'd0})) - 35'(p_reg);
    assign x_hi_abs = x_hi[34] ? 35'(-x_hi) : 35'(x_hi);
    assign x_lo_abs = x_lo[34] ? 35'(-x_lo) : 35'(x_lo);

    // accumulator add, wide enough for any delta
    assign acc_sum = SW'(accum_reg) + SW'(delta_reg);

    // signed view of the unit result and its saturation to the accumulator range
    assign res_s   = res_neg ? -SW'(alu_res) : SW'(alu_res);
    assign sat_res = (res_s > ACC_MAX_S) ? A'(ACC_MAX) :
                     (res_s < ACC_MIN_S) ? A'(ACC_MIN) : res_s[A-1:0];

    // round to nearest, ties up, then clamp to the drive range
    assign rnd_sum   = sum_reg + SW'(2048);
    assign rnd_v     = rnd_sum >>> FRAC_BITS;
    assign floor_s   = SW'(drive_floor_reg);
    assign ceil_s    = SW'(drive_ceiling_reg);
    assign drive_val = (rnd_v < floor_s) ? drive_floor_reg :
                       (rnd_v > ceil_s)  ? drive_ceiling_reg : rnd_v[15:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser || s_tdata[63:48] == 16'd0) ? ST_EMIT : ST_MUL_P;
                end
            end
            ST_MUL_P:     if (alu_done) state_next = ST_MUL_DELTA;
            ST_MUL_DELTA: if (alu_done) state_next = ST_ACC_ADD;
            ST_ACC_ADD:   state_next = (integ_gain_reg != 16'd0) ? ST_HI_MUL : ST_I_MUL;
            ST_HI_MUL:    if (alu_done) state_next = ST_HI_DIV;
            ST_HI_DIV:    if (alu_done) state_next = ST_LO_MUL;
            ST_LO_MUL:    if (alu_done) state_next = ST_LO_DIV;
            ST_LO_DIV:    if (alu_done) state_next = ST_CLAMP;
            ST_CLAMP:     state_next = ST_I_MUL;
            ST_I_MUL:     if (alu_done) state_next = ST_I_DIV;
            ST_I_DIV: begin
                if (alu_done) state_next = first_reg ? ST_F_MUL : ST_D_MUL1;
            end
            ST_D_MUL1:    if (alu_done) state_next = ST_D_MUL2;
            ST_D_MUL2:    if (alu_done) state_next = ST_D_DIV;
            ST_D_DIV:     if (alu_done) state_next = ST_F_MUL;
            ST_F_MUL:     if (alu_done) state_next = ST_FINISH;
            ST_FINISH:    state_next = ST_EMIT;
            ST_EMIT:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs: handshake, unit operands and result sign
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        is_op    = 1'b1;
        alu_a    = '0;
        alu_b    = '0;
        res_neg  = 1'b0;
        alu_req.op = OP_MUL;
        case (state_reg)
            ST_MUL_P: begin
                alu_a = MW'(e_abs); alu_b = prop_gain_reg; res_neg = e_reg[16];
            end
            ST_MUL_DELTA: begin
                alu_a = MW'(e_abs); alu_b = step_reg; res_neg = e_reg[16];
            end
            ST_HI_MUL: begin
                alu_a = MW'(x_hi_abs); alu_b = MS_PER_S;
            end
            ST_LO_MUL: begin
                alu_a = MW'(x_lo_abs); alu_b = MS_PER_S;
            end
            ST_HI_DIV, ST_LO_DIV: begin
                alu_a = t_reg; alu_b = integ_gain_reg; res_neg = tneg_reg;
                alu_req.op = OP_DIV;
            end
            ST_I_MUL: begin
                alu_a = MW'(acc_abs); alu_b = integ_gain_reg;
            end
            ST_I_DIV: begin
                alu_a = t_reg; alu_b = MS_PER_S; res_neg = tneg_reg;
                alu_req.op = OP_DIV;
            end
            ST_D_MUL1: begin
                alu_a = MW'(dm_abs); alu_b = deriv_gain_reg;
            end
            ST_D_MUL2: begin
                alu_a = t_reg; alu_b = MS_PER_S;
            end
            ST_D_DIV: begin
                alu_a = t_reg; alu_b = step_reg; res_neg = !tneg_reg;
                alu_req.op = OP_DIV;
            end
            ST_F_MUL: begin
                alu_a = MW'(ramp_abs); alu_b = rg_abs;
                res_neg = ramp_reg[15] ^ ramp_gain_reg[15];
            end
            default: begin
                is_op = 1'b0;
            end
        endcase
        alu_req.start = is_op && !launched_reg && !alu_done;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            ramp_gain_reg     <= '0;
            drive_floor_reg   <= '0;
            drive_ceiling_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                REG_INTEG_GAIN:    integ_gain_reg    <= cfg_data;
                REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data;
                REG_RAMP_GAIN:     ramp_gain_reg     <= cfg_data;
                REG_DRIVE_FLOOR:   drive_floor_reg   <= cfg_data;
                REG_DRIVE_CEILING: drive_ceiling_reg <= cfg_data;
                default:           prop_gain_reg     <= prop_gain_reg;
            endcase
        end
    end

    // sequencer, controller state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launched_reg <= 1'b0;
            accum_reg    <= '0;
            last_reg     <= '0;
            held_reg     <= '0;
            first_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // unit launch tracking
            if (alu_done) begin
                launched_reg <= 1'b0;
            end else if (alu_req.start) begin
                launched_reg <= 1'b1;
            end

            // input transfer
            if (s_fire) begin
                e_reg    <= 17'(signed'(s_tdata[31:16])) - 17'(signed'(s_tdata[15:0]));
                dm_reg   <= 17'(signed'(s_tdata[15:0])) - 17'(last_reg);
                meas_reg <= s_tdata[15:0];
                ramp_reg <= s_tdata[47:32];
                step_reg <= s_tdata[63:48];
                if (s_tuser) begin
                    accum_reg <= '0;
                    last_reg  <= '0;
                    held_reg  <= '0;
                    first_reg <= 1'b1;
                end
            end

            // collect unit results
            if (alu_done) begin
                case (state_reg)
                    ST_MUL_P: begin
                        p_reg   <= 33'(res_s);
                        sum_reg <= res_s;
                    end
                    ST_MUL_DELTA: delta_reg <= 33'(res_s);
                    ST_HI_MUL: begin
                        t_reg <= alu_res; tneg_reg <= x_hi[34];
                    end
                    ST_LO_MUL: begin
                        t_reg <= alu_res; tneg_reg <= x_lo[34];
                    end
                    ST_HI_DIV: hi_reg <= sat_res;
                    ST_LO_DIV: lo_reg <= sat_res;
                    ST_I_MUL: begin
                        t_reg <= alu_res; tneg_reg <= accum_reg[A-1];
                    end
                    ST_D_MUL1: begin
                        t_reg <= alu_res; tneg_reg <= dm_reg[16];
                    end
                    ST_D_MUL2: t_reg <= alu_res;
                    ST_I_DIV, ST_D_DIV, ST_F_MUL: sum_reg <= sum_reg + res_s;
                    default: t_reg <= t_reg;
                endcase
            end

            // accumulate error with saturation
            if (state_reg == ST_ACC_ADD) begin
                if (acc_sum > ACC_MAX_S) begin
                    accum_reg <= ACC_MAX;
                end else if (acc_sum < ACC_MIN_S) begin
                    accum_reg <= ACC_MIN;
                end else begin
                    accum_reg <= acc_sum[A-1:0];
                end
            end

            // anti-windup clamp, lower bound first
            if (state_reg == ST_CLAMP) begin
                if (accum_reg < lo_reg) begin
                    accum_reg <= lo_reg;
                end else if (accum_reg > hi_reg) begin
                    accum_reg <= hi_reg;
                end
            end

            // final drive
            if (state_reg == ST_FINISH) begin
                held_reg  <= drive_val;
                last_reg  <= meas_reg;
                first_reg <= 1'b0;
            end

            // result transfer
            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= held_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/pidaw_alu.sv =====
module pidaw_alu
    import pidaw_pkg::*;
#(
    parameter int MW = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  alu_req_t                 req,
    input  logic [MW-1:0]            a_in,
    input  logic [15:0]              b_in,
    output logic                     done,
    output logic [MW-1:0]            result
);

    localparam int CW = $clog2(MW + 1);

    logic          busy_reg;
    logic          done_reg;
    alu_op_t       op_reg;
    logic [CW-1:0] cnt_reg;
    logic [MW-1:0] acc_reg;
    logic [MW-1:0] sh_reg;
    logic [15:0]   b_reg;
    logic [15:0]   rem_reg;
    logic [16:0]   trial;
    logic          fits;

    // restoring divide trial: bring down next dividend bit
    assign trial = {rem_reg, sh_reg[MW-1]};
    assign fits  = (trial >= {1'b0, b_reg});

    // one multiplier bit or one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                sh_reg   <= a_in;
                b_reg    <= b_in;
                acc_reg  <= '0;
                rem_reg  <= '0;
                cnt_reg  <= (req.op == OP_MUL) ? CW'(16) : CW'(MW);
            end else if (busy_reg) begin
                case (op_reg)
                    OP_MUL: begin
                        if (b_reg[0]) begin
                            acc_reg <= acc_reg + sh_reg;
                        end
                        sh_reg <= {sh_reg[MW-2:0], 1'b0};
                        b_reg  <= {1'b0, b_reg[15:1]};
                    end
                    OP_DIV: begin
                        rem_reg <= fits ? 16'(trial - {1'b0, b_reg}) : trial[15:0];
                        acc_reg <= {acc_reg[MW-2:0], fits};
                        sh_reg  <= {sh_reg[MW-2:0], 1'b0};
                    end
                    default: begin
                        acc_reg <= acc_reg;
                    end
                endcase
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule
